/* rtl/core/c20_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c20_pkg
// Shared types, constants and block-function helpers for the stream core.
// ---------------------------------------------------------------------------
package c20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_0      = 3'd0;
    localparam logic [2:0] REG_KEY_1      = 3'd1;
    localparam logic [2:0] REG_KEY_2      = 3'd2;
    localparam logic [2:0] REG_KEY_3      = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_INIT_CTR   = 3'd6;

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [63:0] key_0;
        logic [63:0] key_1;
        logic [63:0] key_2;
        logic [63:0] key_3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
    } cfg_t;

    // queued word, already clamped and masked
    typedef struct packed {
        logic [31:0] data;
        logic [31:0] mask;
        logic [2:0]  count;
        logic        start;
    } item_t;

    // back end to key generator: restart with a block counter
    typedef struct packed {
        logic        kick;
        logic [31:0] counter;
    } gen_ctl_t;

    typedef enum logic [1:0] {
        KG_LOAD,
        KG_RUN,
        KG_DONE
    } kg_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [3:0][31:0] quarter(input logic [31:0] a_in,
                                                 input logic [31:0] b_in,
                                                 input logic [31:0] c_in,
                                                 input logic [31:0] d_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction

    // column round when diag is low, diagonal round when high
    function automatic block_t half_round(input block_t w, input logic diag);
        block_t           r;
        logic [3:0][31:0] q;
        r = w;
        if (!diag)
        begin
            q = quarter(w[0], w[4], w[8],  w[12]);
            r[0] = q[0]; r[4] = q[1]; r[8]  = q[2]; r[12] = q[3];
            q = quarter(w[1], w[5], w[9],  w[13]);
            r[1] = q[0]; r[5] = q[1]; r[9]  = q[2]; r[13] = q[3];
            q = quarter(w[2], w[6], w[10], w[14]);
            r[2] = q[0]; r[6] = q[1]; r[10] = q[2]; r[14] = q[3];
            q = quarter(w[3], w[7], w[11], w[15]);
            r[3] = q[0]; r[7] = q[1]; r[11] = q[2]; r[15] = q[3];
        end
        else
        begin
            q = quarter(w[0], w[5], w[10], w[15]);
            r[0] = q[0]; r[5] = q[1]; r[10] = q[2]; r[15] = q[3];
            q = quarter(w[1], w[6], w[11], w[12]);
            r[1] = q[0]; r[6] = q[1]; r[11] = q[2]; r[12] = q[3];
            q = quarter(w[2], w[7], w[8],  w[13]);
            r[2] = q[0]; r[7] = q[1]; r[8]  = q[2]; r[13] = q[3];
            q = quarter(w[3], w[4], w[9],  w[14]);
            r[3] = q[0]; r[4] = q[1]; r[9]  = q[2]; r[14] = q[3];
        end
        half_round = r;
    endfunction

    function automatic block_t make_init(input cfg_t cfg, input logic [31:0] ctr);
        block_t s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        s[4]  = cfg.key_0[31:0];
        s[5]  = cfg.key_0[63:32];
        s[6]  = cfg.key_1[31:0];
        s[7]  = cfg.key_1[63:32];
        s[8]  = cfg.key_2[31:0];
        s[9]  = cfg.key_2[63:32];
        s[10] = cfg.key_3[31:0];
        s[11] = cfg.key_3[63:32];
        s[12] = ctr;
        s[13] = cfg.nonce_low[31:0];
        s[14] = cfg.nonce_low[63:32];
        s[15] = cfg.nonce_high;
        make_init = s;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/c20_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c20_front
// Accepts input words, clamps the byte count, masks the data and queues them.
// ---------------------------------------------------------------------------
module c20_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [31:0]   data_in,
    input  wire logic [2:0]    byte_count,
    input  wire logic          message_start,
    output logic               head_valid,
    output c20_pkg::item_t     head,
    input  wire logic          pop
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    c20_pkg::item_t     fifo_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW:0]        fill_reg, fill_next;
    logic               push;
    logic [2:0]         count_c;
    logic [31:0]        mask_c;
    c20_pkg::item_t     item_c;

    // clamp count and build byte mask
    always_comb
    begin
        case (byte_count)
            3'd0, 3'd1: count_c = 3'd1;
            3'd2:       count_c = 3'd2;
            3'd3:       count_c = 3'd3;
            default:    count_c = 3'd4;
        endcase
        case (count_c)
            3'd1:    mask_c = 32'h0000_00ff;
            3'd2:    mask_c = 32'h0000_ffff;
            3'd3:    mask_c = 32'h00ff_ffff;
            default: mask_c = 32'hffff_ffff;
        endcase
        item_c.data  = data_in & mask_c;
        item_c.mask  = mask_c;
        item_c.count = count_c;
        item_c.start = message_start;
    end

    assign in_stall   = (fill_reg == (AW+1)'(DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (fill_reg != '0);
    assign head       = fifo_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_c;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/c20_keygen.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c20_keygen
// Block function engine: one column or diagonal round per cycle.
// ---------------------------------------------------------------------------
module c20_keygen #(
    parameter int DOUBLE_ROUNDS = c20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire c20_pkg::cfg_t     cfg,
    input  wire c20_pkg::gen_ctl_t ctl,
    output logic                   done,
    output c20_pkg::block_t        block
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RW     = $clog2(ROUNDS);

    c20_pkg::kg_state_t state_reg, state_next;
    logic [RW-1:0]      rnd_reg;
    logic [31:0]        ctr_reg;
    c20_pkg::block_t    init_reg;
    c20_pkg::block_t    work_reg;
    logic               last_rnd;

    assign last_rnd = (rnd_reg == RW'(ROUNDS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c20_pkg::KG_LOAD: state_next = c20_pkg::KG_RUN;
            c20_pkg::KG_RUN:  state_next = last_rnd ? c20_pkg::KG_DONE : c20_pkg::KG_RUN;
            c20_pkg::KG_DONE: state_next = c20_pkg::KG_DONE;
            default:          state_next = c20_pkg::KG_LOAD;
        endcase
        if (ctl.kick)
        begin
            state_next = c20_pkg::KG_LOAD;
        end
    end

    // outputs
    always_comb
    begin
        case (state_reg)
            c20_pkg::KG_DONE: done = 1'b1;
            default:          done = 1'b0;
        endcase
        for (int i = 0; i < 16; i++)
        begin
            block[i] = work_reg[i] + init_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c20_pkg::KG_LOAD;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.kick)
            begin
                ctr_reg <= ctl.counter;
            end
        end
    end

    // round datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            c20_pkg::KG_LOAD:
            begin
                init_reg <= c20_pkg::make_init(cfg, ctr_reg);
                work_reg <= c20_pkg::make_init(cfg, ctr_reg);
                rnd_reg  <= '0;
            end
            c20_pkg::KG_RUN:
            begin
                work_reg <= c20_pkg::half_round(work_reg, rnd_reg[0]);
                rnd_reg  <= rnd_reg + 1'b1;
            end
            default:
            begin
                rnd_reg <= rnd_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/c20_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c20_back
// Holds the current keystream block, tracks the counter and drives results.
// ---------------------------------------------------------------------------
module c20_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire c20_pkg::item_t    head,
    output logic                   pop,
    input  wire logic              cfg_kick,
    input  wire logic [31:0]       initial_counter,
    output c20_pkg::gen_ctl_t      ctl,
    input  wire logic              gen_done,
    input  wire c20_pkg::block_t   gen_block,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            data_out,
    output logic [2:0]             byte_count_out
);

    c20_pkg::block_t cur_reg;
    logic            cur_valid_reg, cur_valid_next;
    logic [3:0]      wpos_reg, wpos_next;
    logic [31:0]     ctr_reg, ctr_next;
    logic            taken_reg, taken_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     data_out_reg;
    logic [2:0]      count_out_reg;
    logic            start_pend;
    logic            load_blk;

    assign start_pend = head_valid && head.start && !taken_reg;
    assign load_blk   = gen_done && !cur_valid_reg && !start_pend && !cfg_kick;
    assign pop        = head_valid && !start_pend && cur_valid_reg
                        && (!out_valid_reg || !out_stall);

    // control next values
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        wpos_next      = wpos_reg;
        ctr_next       = ctr_reg;
        taken_next     = taken_reg;
        ctl.kick       = 1'b0;
        ctl.counter    = ctr_reg;
        if (start_pend)
        begin
            cur_valid_next = 1'b0;
            ctr_next       = initial_counter;
            taken_next     = 1'b1;
            ctl.kick       = 1'b1;
            ctl.counter    = initial_counter;
        end
        else if (cfg_kick)
        begin
            ctl.kick = 1'b1;
            // an untouched buffered block is rebuilt with the new settings
            if (cur_valid_reg && wpos_reg == 4'h0 && !pop)
            begin
                cur_valid_next = 1'b0;
                ctr_next       = ctr_reg - 32'd1;
                ctl.counter    = ctr_reg - 32'd1;
            end
        end
        else if (load_blk)
        begin
            cur_valid_next = 1'b1;
            wpos_next      = '0;
            ctr_next       = ctr_reg + 32'd1;
            ctl.kick       = 1'b1;
            ctl.counter    = ctr_reg + 32'd1;
        end
        if (pop)
        begin
            wpos_next  = wpos_reg + 1'b1;
            taken_next = 1'b0;
            if (wpos_reg == 4'hf)
            begin
                cur_valid_next = 1'b0;
            end
        end
        out_valid_next = pop || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            wpos_reg      <= '0;
            ctr_reg       <= '0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            wpos_reg      <= wpos_next;
            ctr_reg       <= ctr_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // keystream buffer and output payload
    always_ff @(posedge clk)
    begin
        if (load_blk)
        begin
            cur_reg <= gen_block;
        end
        if (pop)
        begin
            data_out_reg  <= (head.data ^ cur_reg[wpos_reg]) & head.mask;
            count_out_reg <= head.count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = data_out_reg;
    assign byte_count_out = count_out_reg;

endmodule
`default_nettype wire

/* rtl/core/chacha20_stream_xor_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chacha20_stream_xor_core
// Stream cipher core: XORs 32-bit data words with a block-function keystream.
// ---------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   data_in, byte_count, message_start
// out       source     out_valid/out_stall data_out, byte_count_out
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// a word passes through the queue and the output register when its keystream
// block is buffered; one word per cycle while a block lasts and out_stall is low.
// a block goes from kick through the load, round and done states into the buffer,
// which the pop of word 15 frees; the next block is built while one is read out.
// a message start's first word waits until a block at the initial counter is buffered.
// reset starts the counter zero block; a four-entry queue splits the stalls.
// ---------------------------------------------------------------------------
module chacha20_stream_xor_core #(
    parameter int DOUBLE_ROUNDS = c20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] data_in,
    input  wire logic [2:0]  byte_count,
    input  wire logic        message_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      data_out,
    output logic [2:0]       byte_count_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    c20_pkg::cfg_t     cfg_reg;
    logic [31:0]       init_ctr_reg;
    logic              cfg_wr;
    logic              head_valid;
    c20_pkg::item_t    head;
    logic              pop;
    c20_pkg::gen_ctl_t ctl;
    logic              gen_done;
    c20_pkg::block_t   gen_block;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                c20_pkg::REG_KEY_0:      cfg_reg.key_0      <= cfg_data;
                c20_pkg::REG_KEY_1:      cfg_reg.key_1      <= cfg_data;
                c20_pkg::REG_KEY_2:      cfg_reg.key_2      <= cfg_data;
                c20_pkg::REG_KEY_3:      cfg_reg.key_3      <= cfg_data;
                c20_pkg::REG_NONCE_LOW:  cfg_reg.nonce_low  <= cfg_data;
                c20_pkg::REG_NONCE_HIGH: cfg_reg.nonce_high <= cfg_data[31:0];
                c20_pkg::REG_INIT_CTR:   init_ctr_reg       <= cfg_data[31:0];
                default:                 init_ctr_reg       <= init_ctr_reg;
            endcase
        end
    end

    c20_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_in       (data_in),
        .byte_count    (byte_count),
        .message_start (message_start),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop)
    );

    c20_keygen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_keygen (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (ctl),
        .done  (gen_done),
        .block (gen_block)
    );

    c20_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .cfg_kick        (cfg_wr),
        .initial_counter (init_ctr_reg),
        .ctl             (ctl),
        .gen_done        (gen_done),
        .gen_block       (gen_block),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_out        (data_out),
        .byte_count_out  (byte_count_out)
    );

endmodule
`default_nettype wire
